FILE: src/rrc_pkg.sv
// Shared constants for the running rank counter: default parameters,
// fixed stream field widths and the tag width of the count memory.
// No dependencies.
package rrc_pkg;

    localparam int VALUE_BITS_DEF = 14;
    localparam int COUNT_BITS_DEF = 16;

    // Stream field widths fixed by the item format
    localparam int IN_VALUE_W   = 14;
    localparam int OUT_COUNT_W  = 16;
    localparam int S_TDATA_W    = 16;
    localparam int M_TDATA_W    = 16;

    // Generation tag kept with each memory word; a stale tag reads as zero
    localparam int EPOCH_BITS   = 8;

endpackage

FILE: src/running_rank_counter.sv
// Running rank counter: per-value counts in a Fenwick tree held in one
// synchronous memory, walked by a read-modify-write sequencer.
// Depends on rrc_pkg.
//
//  channel   dir  tdata                         tuser
//  s_axis    in   [13:0] value, [15:14] zero    [0] start_new
//  m_axis    out  [15:0] smaller_count          [0] count_saturated
//
// An item is taken in S_IDLE; the query path (S_QUERY) and the update path (S_UPD)
// together touch VALUE_BITS+1 entries, one memory access a cycle, and each ends in a
// step of its own; S_DONE then loads the result once the output register is free.
// After reset a clearing pass over all 2^VALUE_BITS entries runs before the first
// item; the same pass runs on every 2^EPOCH_BITS-th start_new item.
// A result waits in the output register while the next item is taken.
module running_rank_counter
    import rrc_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // [13:0] value
    input  logic                 s_axis_tuser,   // [0] start_new
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,   // [15:0] smaller_count
    output logic                 m_axis_tuser    // [0] count_saturated
);

    localparam int IW     = VALUE_BITS + 2;
    localparam int DEPTH  = 1 << VALUE_BITS;
    localparam int WW     = EPOCH_BITS + COUNT_BITS;

    localparam logic [IW-1:0]         TREE_SIZE = IW'(DEPTH);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_QUERY = 3'd2;
    localparam logic [2:0] S_UPD   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [WW-1:0] mem [DEPTH];
    logic [WW-1:0] r_rd_data;

    logic [2:0]             r_state, n_state;
    logic [IW-1:0]          r_idx, n_idx;
    logic                   r_rd_pend, n_rd_pend;
    logic [VALUE_BITS-1:0]  r_pend_addr, n_pend_addr;
    logic [VALUE_BITS-1:0]  r_v, n_v;
    logic [COUNT_BITS-1:0]  r_sum, n_sum;
    logic                   r_sat, n_sat;
    logic [EPOCH_BITS-1:0]  r_epoch, n_epoch;
    logic [VALUE_BITS-1:0]  r_clr, n_clr;
    logic                   r_item, n_item;
    logic                   r_out_vld, n_out_vld;
    logic [COUNT_BITS-1:0]  r_out_cnt, n_out_cnt;
    logic                   r_out_sat, n_out_sat;

    logic                   w_we, w_re;
    logic [VALUE_BITS-1:0]  w_waddr, w_raddr;
    logic [WW-1:0]          w_wdata;

    logic [31:0]            w_in_ext, w_out_ext;
    logic [IW-1:0]          w_low_bit, w_idx_m1;
    logic [COUNT_BITS-1:0]  w_eff;
    logic [COUNT_BITS:0]    w_add;
    logic                   w_in_xfer, w_out_free;

    assign w_in_xfer  = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_out_vld || m_axis_tready;
    assign w_in_ext   = 32'(s_axis_tdata[IN_VALUE_W-1:0]);
    assign w_low_bit  = r_idx & (~r_idx + IW'(1));
    assign w_idx_m1   = r_idx - IW'(1);
    assign w_eff      = (r_rd_data[WW-1:COUNT_BITS] == r_epoch) ?
                        r_rd_data[COUNT_BITS-1:0] : '0;
    assign w_add      = {1'b0, r_sum} + {1'b0, w_eff};

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_rd_pend   = 1'b0;
        n_pend_addr = r_pend_addr;
        n_v         = r_v;
        n_sum       = r_sum;
        n_sat       = r_sat;
        n_epoch     = r_epoch;
        n_clr       = r_clr;
        n_item      = r_item;
        n_out_vld   = r_out_vld && !m_axis_tready;
        n_out_cnt   = r_out_cnt;
        n_out_sat   = r_out_sat;
        w_we        = 1'b0;
        w_waddr     = r_pend_addr;
        w_wdata     = '0;
        w_re        = 1'b0;
        w_raddr     = w_idx_m1[VALUE_BITS-1:0];

        case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = '0;
                n_clr   = r_clr + VALUE_BITS'(1);
                if (r_clr == '1) begin
                    n_state = r_item ? S_QUERY : S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_v    = w_in_ext[VALUE_BITS-1:0];
                    n_idx  = IW'(w_in_ext[VALUE_BITS-1:0]);
                    n_sum  = '0;
                    n_sat  = 1'b0;
                    n_item = 1'b1;
                    n_state = S_QUERY;
                    if (s_axis_tuser) begin
                        n_epoch = r_epoch + EPOCH_BITS'(1);
                        if (n_epoch == '0) begin
                            n_clr   = '0;
                            n_state = S_CLEAR;
                        end
                    end
                end
            end
            S_QUERY: begin
                if (r_rd_pend) begin
                    if (w_add[COUNT_BITS]) begin
                        n_sum = COUNT_MAX;
                        n_sat = 1'b1;
                    end else begin
                        n_sum = w_add[COUNT_BITS-1:0];
                    end
                end
                if (r_idx != '0) begin
                    w_re      = 1'b1;
                    n_rd_pend = 1'b1;
                    n_idx     = r_idx - w_low_bit;
                end else begin
                    n_idx   = IW'(r_v) + IW'(1);
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                if (r_rd_pend) begin
                    w_we = 1'b1;
                    if (w_eff == COUNT_MAX) begin
                        n_sat   = 1'b1;
                        w_wdata = {r_epoch, w_eff};
                    end else begin
                        w_wdata = {r_epoch, w_eff + COUNT_BITS'(1)};
                    end
                end
                if (r_idx <= TREE_SIZE) begin
                    w_re        = 1'b1;
                    n_rd_pend   = 1'b1;
                    n_pend_addr = w_idx_m1[VALUE_BITS-1:0];
                    n_idx       = r_idx + w_low_bit;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_vld = 1'b1;
                    n_out_cnt = r_sum;
                    n_out_sat = r_sat;
                    n_item    = 1'b0;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd_data <= mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_epoch   <= '0;
            r_item    <= 1'b0;
            r_rd_pend <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_epoch   <= n_epoch;
            r_item    <= n_item;
            r_rd_pend <= n_rd_pend;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_pend_addr <= n_pend_addr;
        r_v         <= n_v;
        r_sum       <= n_sum;
        r_sat       <= n_sat;
        r_out_cnt   <= n_out_cnt;
        r_out_sat   <= n_out_sat;
    end

    assign w_out_ext     = 32'(r_out_cnt);
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = w_out_ext[OUT_COUNT_W-1:0];
    assign m_axis_tuser  = r_out_sat;

endmodule

FILE: src/rrc_checker.sv
// Port-level checker for the running rank counter, bound to the top level.
// Depends on rrc_pkg and running_rank_counter.
module rrc_checker
    import rrc_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic                 m_axis_tuser
);

    logic       w_in_xfer, w_out_xfer;
    logic [1:0] r_open;

    assign w_in_xfer  = s_axis_tvalid && s_axis_tready;
    assign w_out_xfer = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= '0;
        end else begin
            r_open <= r_open + 2'(w_in_xfer) - 2'(w_out_xfer);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> !s_axis_tready)
        else $error("input taken on consecutive cycles");

    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_xfer |-> r_open != 2'd0)
        else $error("result transfer without an open item");

    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open != 2'd3)
        else $error("too many items in flight");

endmodule

bind running_rank_counter rrc_checker u_rrc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: test/running_rank_counter_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for running_rank_counter: streams arrays of values
// with random idling on both sides and checks every rank against a Fenwick-tree predictor.
// Depends on rrc_pkg and running_rank_counter.
module running_rank_counter_tb;
    import rrc_pkg::*;

    // default tree and counter widths; values span the whole field
    localparam int VAL_BITS = VALUE_BITS_DEF;
    localparam int CNT_BITS = COUNT_BITS_DEF;
    localparam int TREE_SIZE = 1 << VAL_BITS;
    localparam longint CNT_MAX = (64'd1 << CNT_BITS) - 1;
    localparam int ITEM_TARGET = 1600;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int MAX_REPORTS = 40;
    localparam int FIELD_MAX = (1 << IN_VALUE_W) - 1;

    typedef enum int {MIX_SPREAD, MIX_CLUSTER, MIX_EDGES} value_mix_e;

    typedef struct packed {
        logic                  drain_first;
        logic                  start_new;
        logic [IN_VALUE_W-1:0] value;
    } rank_item_t;

    typedef struct packed {
        logic                   saturated;
        logic [OUT_COUNT_W-1:0] smaller;
    } rank_result_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;    // [13:0] value, [15:14] zero
    logic                 s_axis_tuser = 1'b0;  // [0] start_new
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;         // [15:0] smaller_count
    logic                 m_axis_tuser;         // [0] count_saturated

    logic [CNT_BITS-1:0] fen_counts [0:TREE_SIZE];
    rank_item_t          pending_items [$];
    rank_result_t        expected_ranks [$];
    rank_item_t          current_item;

    int mismatches = 0;
    int results_checked = 0;
    int saturated_seen = 0;
    int items_queued = 0;
    int arrays_queued = 0;
    int cycle_count = 0;
    int send_gap = 0;
    int send_calm = 0;
    int recv_stall = 0;
    int recv_calm = 0;

    running_rank_counter #(
        .VALUE_BITS(VAL_BITS),
        .COUNT_BITS(CNT_BITS)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic clear_counts();
        for (int k = 0; k <= TREE_SIZE; k++) begin
            fen_counts[k] = '0;
        end
    endtask

    // Count earlier values strictly below this one, then record it.
    task automatic rank_value(input rank_item_t item, output rank_result_t res);
        int     slot;
        int     idx;
        longint total;
        logic   clamped;
        clamped = 1'b0;
        total = 0;
        if (item.start_new) begin
            clear_counts();
        end
        slot = int'(item.value) % TREE_SIZE;
        idx = slot;
        while (idx > 0) begin
            total += fen_counts[idx];
            if (total > CNT_MAX) begin
                total = CNT_MAX;
                clamped = 1'b1;
            end
            idx -= idx & -idx;
        end
        idx = slot + 1;
        while (idx <= TREE_SIZE) begin
            if (&fen_counts[idx]) begin
                clamped = 1'b1;
            end else begin
                fen_counts[idx] = fen_counts[idx] + 1'b1;
            end
            idx += idx & -idx;
        end
        res.smaller = total[OUT_COUNT_W-1:0];
        res.saturated = clamped;
    endtask

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("MISMATCH at result %0d: %s", results_checked, msg);
        end
    endtask

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int mixed_value(input value_mix_e mix, input int base);
        case (mix)
            MIX_CLUSTER: begin
                return (base + $urandom_range(0, 3)) % (FIELD_MAX + 1);
            end
            MIX_EDGES: begin
                case ($urandom_range(0, 5))
                    0: return 0;
                    1: return 1;
                    2: return TREE_SIZE - 1;
                    3: return TREE_SIZE;
                    4: return FIELD_MAX;
                    default: return $urandom_range(0, FIELD_MAX);
                endcase
            end
            default: begin
                return $urandom_range(0, FIELD_MAX);
            end
        endcase
    endfunction

    task automatic add_item(input int value, input logic start, input logic drain);
        rank_item_t item;
        item.value = value[IN_VALUE_W-1:0];
        item.start_new = start;
        item.drain_first = drain;
        pending_items.push_back(item);
        items_queued++;
        if (start) arrays_queued++;
    endtask

    task automatic add_array(input int len, input value_mix_e mix, input logic drain);
        int base;
        base = $urandom_range(0, FIELD_MAX);
        for (int k = 0; k < len; k++) begin
            add_item(mixed_value(mix, base), k == 0, drain && (k == 0));
        end
    endtask

    // Input side: present queued items, predict each one as it transfers.
    always @(posedge i_clk) begin : drive_input
        rank_result_t predicted;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                rank_value(current_item, predicted);
                expected_ranks.push_back(predicted);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_items.size() > 0 &&
                             !(pending_items[0].drain_first && expected_ranks.size() > 0)) begin
                    current_item = pending_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {{(S_TDATA_W-IN_VALUE_W){1'b0}}, current_item.value};
                    s_axis_tuser <= current_item.start_new;
                    if (send_calm > 0) begin
                        send_calm--;
                        send_gap = 0;
                    end else begin
                        send_gap = idle_length();
                        if ($urandom_range(0, 49) == 0) send_calm = $urandom_range(30, 120);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output side: stall at random, check every transfer against the oldest prediction.
    always @(posedge i_clk) begin : watch_output
        rank_result_t want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_ranks.size() == 0) begin
                    report_mismatch($sformatf("unexpected result count=%0d sat=%0d",
                                              m_axis_tdata, m_axis_tuser));
                end else begin
                    want = expected_ranks.pop_front();
                    if (m_axis_tdata !== want.smaller) begin
                        report_mismatch($sformatf("smaller_count %0d, want %0d",
                                                  m_axis_tdata, want.smaller));
                    end
                    if (m_axis_tuser !== want.saturated) begin
                        report_mismatch($sformatf("count_saturated %0b, want %0b",
                                                  m_axis_tuser, want.saturated));
                    end
                    if (want.saturated) saturated_seen++;
                end
                results_checked++;
            end
            if (recv_stall > 0) begin
                recv_stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (recv_calm > 0) begin
                    recv_calm--;
                end else if ($urandom_range(0, 7) == 0) begin
                    recv_stall = idle_length();
                end else if ($urandom_range(0, 199) == 0) begin
                    recv_calm = $urandom_range(50, 400);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d items pending, %0d results outstanding",
                     cycle_count, pending_items.size(), expected_ranks.size());
            $display("simulation failed");
            $finish;
        end
    end

    initial begin : stimulus
        int len;
        int r;
        clear_counts();

        // directed: first items, equal values, wrapping values, back-to-back starts
        add_item(0, 1'b1, 1'b0);
        add_item(0, 1'b0, 1'b0);
        add_item(FIELD_MAX, 1'b0, 1'b0);
        add_item(TREE_SIZE - 1, 1'b0, 1'b0);
        add_item(TREE_SIZE, 1'b0, 1'b0);
        add_item(1, 1'b0, 1'b0);
        add_item(TREE_SIZE / 2, 1'b0, 1'b0);
        add_item(TREE_SIZE / 2 - 1, 1'b0, 1'b0);
        add_item(2 * TREE_SIZE - 1, 1'b0, 1'b0);
        add_item(3 * TREE_SIZE + 5, 1'b0, 1'b0);
        add_item(FIELD_MAX, 1'b1, 1'b0);
        add_item(FIELD_MAX, 1'b0, 1'b0);
        add_item(0, 1'b0, 1'b0);
        add_item(5, 1'b1, 1'b0);
        add_item(5, 1'b1, 1'b0);
        add_item(4, 1'b0, 1'b0);
        add_item(6, 1'b0, 1'b0);
        add_item(TREE_SIZE + 5, 1'b0, 1'b0);
        add_item(10922, 1'b0, 1'b0);
        add_item(5461, 1'b0, 1'b0);

        // long arrays first, the first one behind a full drain
        add_array($urandom_range(300, 380), MIX_SPREAD, 1'b1);
        add_array($urandom_range(270, 330), MIX_CLUSTER, 1'b0);
        while (items_queued < ITEM_TARGET) begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 59) == 0) len = $urandom_range(260, 380);
            else if (r < 30) len = 1;
            else len = $urandom_range(2, 10);
            r = $urandom_range(0, 3);
            add_array(len, (r < 2) ? MIX_SPREAD : (r == 2) ? MIX_CLUSTER : MIX_EDGES,
                      $urandom_range(0, 149) == 0);
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() > 0 || s_axis_tvalid) @(posedge i_clk);
        while (expected_ranks.size() > 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        $display("ranked %0d values in %0d arrays, %0d results checked, %0d saturated",
                 items_queued, arrays_queued, results_checked, saturated_seen);
        if (mismatches == 0 && expected_ranks.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
